### design/radial_alpha_mask_pixel_assert.svh
// Assertion macros for the radial alpha mask design.
`ifndef RADIAL_ALPHA_MASK_PIXEL_ASSERT_SVH
`define RADIAL_ALPHA_MASK_PIXEL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RAMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ramp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ramp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_SIZE  = 1024;
    localparam int W_W       = 11;                 // mask side
    localparam int W2_W      = 21;                 // side squared
    localparam int S_W       = 23;                 // sum of squared offsets
    localparam int Q_W       = 2 * FRAC_BITS + 3;  // squared distance, Q3.32
    localparam int REM_W     = 21;
    localparam int SQ_N      = 18;                 // root digits
    localparam int D_W       = 18;                 // distance Q2.16
    localparam int X_W       = 17;                 // band position Q1.16
    localparam int CW        = 44;                 // bell coefficients Q.32
    localparam int P_W       = CW + X_W + 1;
    localparam int ADDR_W    = 4;

    localparam logic [X_W-1:0]       ONE       = X_W'(1) << FRAC_BITS;
    localparam logic [15:0]          ALPHA_MAX = 16'hFFFF;
    localparam logic signed [CW-1:0] UNIT      = CW'(64'sd1 <<< 32);

    typedef enum logic [1:0] {
        REG_MASK_SIZE   = 2'd0,
        REG_FLAT_RADIUS = 2'd1,
        REG_INNER_SLOPE = 2'd2,
        REG_OUTER_SLOPE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                 zero_size;
        logic [W_W-1:0]       w;
        logic [W2_W-1:0]      w2;
        logic [16:0]          flat;
        logic signed [CW-1:0] s0;
        logic signed [CW-1:0] a2;
        logic signed [CW-1:0] a3;
    } t_cfg;

    typedef struct packed {
        logic opaque;
        logic zero;
    } t_flags;

endpackage
`default_nettype wire

### design/ramp_pix_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ramp_pix_if;
    logic       valid;
    logic       ready;
    logic [9:0] col;
    logic [9:0] row;
    modport source (output valid, output col, output row, input ready);
    modport sink   (input valid, input col, input row, output ready);
endinterface
`default_nettype wire

### design/ramp_alpha_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ramp_alpha_if;
    logic        valid;
    logic        ready;
    logic [15:0] alpha;
    modport source (output valid, output alpha, input ready);
    modport sink   (input valid, input alpha, output ready);
endinterface
`default_nettype wire

### design/ramp_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module ramp_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ramp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output ramp_pkg::t_cfg                  o_cfg
);
    import ramp_pkg::*;

    logic [W_W-1:0]       r_size;
    logic [16:0]          r_flat;
    logic signed [15:0]   r_inner;
    logic signed [15:0]   r_outer;
    t_reg_idx             idx;
    logic                 wr;
    logic [W_W-1:0]       w_sat;
    logic signed [CW-1:0] s0;
    logic signed [CW-1:0] s1;

    assign idx    = t_reg_idx'(paddr[3:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= W_W'(5);
            r_flat  <= '0;
            r_inner <= '0;
            r_outer <= '0;
        end else if (wr) begin
            case (idx)
                REG_MASK_SIZE:   r_size  <= pwdata[W_W-1:0];
                REG_FLAT_RADIUS: r_flat  <= pwdata[16:0];
                REG_INNER_SLOPE: r_inner <= pwdata[15:0];
                REG_OUTER_SLOPE: r_outer <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MASK_SIZE:   prdata = {21'd0, r_size};
            REG_FLAT_RADIUS: prdata = {15'd0, r_flat};
            REG_INNER_SLOPE: prdata = {16'd0, r_inner};
            REG_OUTER_SLOPE: prdata = {16'd0, r_outer};
            default:         prdata = '0;
        endcase
    end

    // Slopes are Q4.12; bell coefficients are Q.32 with negated end slopes.
    assign w_sat = (r_size > W_W'(MAX_SIZE)) ? W_W'(MAX_SIZE) : r_size;
    assign s0    = -(CW'(r_inner) <<< 20);
    assign s1    = -(CW'(r_outer) <<< 20);

    always_ff @(posedge i_clk) begin
        o_cfg.zero_size <= (r_size == '0);
        o_cfg.w         <= w_sat;
        o_cfg.w2        <= W2_W'(w_sat) * W2_W'(w_sat);
        o_cfg.flat      <= r_flat;
        o_cfg.s0        <= s0;
        o_cfg.a2        <= -s1 - (s0 <<< 1) - (UNIT <<< 1) - UNIT;
        o_cfg.a3        <= s1 + s0 + (UNIT <<< 1);
    end
endmodule
`default_nettype wire

### design/ramp_dist.sv
`timescale 1ns / 1ps
`default_nettype none
module ramp_dist (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_vld,
    input  wire logic [9:0]              i_col,
    input  wire logic [9:0]              i_row,
    input  wire ramp_pkg::t_cfg          i_cfg,
    output logic                         o_vld,
    output logic                         o_kill,
    output logic [ramp_pkg::D_W-1:0]     o_d
);
    import ramp_pkg::*;

    logic                     r_v0, r_v1, r_v2;
    logic [9:0]               r_col, r_row;
    logic signed [11:0]       r_ex, r_ey;
    logic [S_W-1:0]           r_s;

    // long division stages: index k holds the state after k quotient bits
    logic                     r_dv   [0:Q_W];
    logic                     r_dk   [0:Q_W];
    logic [REM_W-1:0]         r_rem  [0:Q_W];
    logic [Q_W-1:0]           r_q    [0:Q_W];
    logic [2:0]               r_slo  [0:Q_W];

    // root stages
    logic                     r_sv   [0:SQ_N];
    logic                     r_sk   [0:SQ_N];
    logic [Q_W-1:0]           r_val  [0:SQ_N];
    logic [Q_W:0]             r_res  [0:SQ_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0     <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_dv[0]  <= 1'b0;
        end else if (i_en) begin
            r_v0     <= i_vld;
            r_v1     <= r_v0;
            r_v2     <= r_v1;
            r_dv[0]  <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col    <= i_col;
            r_row    <= i_row;
            r_ex     <= $signed({1'b0, r_col, 1'b0}) - $signed({1'b0, i_cfg.w});
            r_ey     <= $signed({1'b0, r_row, 1'b0}) - $signed({1'b0, i_cfg.w});
            r_s      <= (S_W'(r_ex) * S_W'(r_ex)) + (S_W'(r_ey) * S_W'(r_ey));
            r_dk[0]  <= i_cfg.zero_size || (r_s > {i_cfg.w2, 2'b00});
            r_rem[0] <= REM_W'(r_s >> 3);
            r_q[0]   <= '0;
            r_slo[0] <= r_s[2:0];
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_div
        logic              nb;
        logic [REM_W:0]    t;
        logic              ge;
        if (k <= 3) begin : g_nb
            assign nb = r_slo[k-1][3-k];
        end else begin : g_zero
            assign nb = 1'b0;
        end
        assign t  = {r_rem[k-1], nb};
        assign ge = t >= (REM_W+1)'(i_cfg.w2);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (i_en) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dk[k]  <= r_dk[k-1];
                r_slo[k] <= r_slo[k-1];
                r_rem[k] <= ge ? REM_W'(t - (REM_W+1)'(i_cfg.w2)) : REM_W'(t);
                r_q[k]   <= {r_q[k-1][Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv[0] <= 1'b0;
        end else if (i_en) begin
            r_sv[0] <= r_dv[Q_W];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sk[0]  <= r_dk[Q_W];
            r_val[0] <= r_q[Q_W];
            r_res[0] <= '0;
        end
    end

    for (genvar j = 1; j <= SQ_N; j++) begin : g_sqrt
        localparam logic [Q_W:0] BIT = (Q_W+1)'(1) << (2 * (SQ_N - j));
        logic [Q_W:0] sum;
        logic         ge;
        assign sum = r_res[j-1] + BIT;
        assign ge  = {1'b0, r_val[j-1]} >= sum;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[j] <= 1'b0;
            end else if (i_en) begin
                r_sv[j] <= r_sv[j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sk[j]  <= r_sk[j-1];
                r_val[j] <= ge ? r_val[j-1] - sum[Q_W-1:0] : r_val[j-1];
                r_res[j] <= ge ? (r_res[j-1] >> 1) + BIT : r_res[j-1] >> 1;
            end
        end
    end

    assign o_vld  = r_sv[SQ_N];
    assign o_kill = r_sk[SQ_N];
    assign o_d    = r_res[SQ_N][D_W-1:0];
endmodule
`default_nettype wire

### design/ramp_band.sv
`timescale 1ns / 1ps
`default_nettype none
module ramp_band (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_vld,
    input  wire logic                    i_kill,
    input  wire logic [ramp_pkg::D_W-1:0] i_d,
    input  wire ramp_pkg::t_cfg          i_cfg,
    output logic                         o_vld,
    output ramp_pkg::t_flags             o_flags,
    output logic [ramp_pkg::X_W-1:0]     o_x
);
    import ramp_pkg::*;

    localparam int N = X_W;

    logic             r_v    [0:N];
    t_flags           r_fl   [0:N];
    logic             r_big  [0:N];
    logic [X_W-1:0]   r_d    [0:N];
    logic [X_W-1:0]   r_dv   [0:N];
    logic             r_lsb  [0:N];
    logic [X_W-1:0]   r_rem  [0:N];
    logic [X_W-1:0]   r_q    [0:N];

    logic             opaque;
    logic [X_W-1:0]   diff;

    assign opaque = !i_kill && (i_d < D_W'(i_cfg.flat));
    assign diff   = X_W'(i_d - D_W'(i_cfg.flat));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fl[0].opaque <= opaque;
            r_fl[0].zero   <= i_kill || (!opaque && i_d > D_W'(ONE));
            r_big[0]       <= i_cfg.flat >= ONE;
            r_d[0]         <= i_d[X_W-1:0];
            r_dv[0]        <= ONE - i_cfg.flat;
            r_lsb[0]       <= diff[0];
            r_rem[0]       <= diff >> 1;
            r_q[0]         <= '0;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_div
        logic          nb;
        logic [X_W:0]  t;
        logic          ge;
        if (k == 1) begin : g_nb
            assign nb = r_lsb[0];
        end else begin : g_zero
            assign nb = 1'b0;
        end
        assign t  = {r_rem[k-1], nb};
        assign ge = t >= {1'b0, r_dv[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_fl[k]  <= r_fl[k-1];
                r_big[k] <= r_big[k-1];
                r_d[k]   <= r_d[k-1];
                r_dv[k]  <= r_dv[k-1];
                r_lsb[k] <= r_lsb[k-1];
                r_rem[k] <= ge ? X_W'(t - {1'b0, r_dv[k-1]}) : X_W'(t);
                r_q[k]   <= {r_q[k-1][X_W-2:0], ge};
            end
        end
    end

    // A flat radius at or above one leaves at most d == 1.0 in the band.
    assign o_vld   = r_v[N];
    assign o_flags = r_fl[N];
    assign o_x     = r_big[N] ? r_d[N] : r_q[N];
endmodule
`default_nettype wire

### design/ramp_bell.sv
`timescale 1ns / 1ps
`default_nettype none
module ramp_bell (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_vld,
    input  wire ramp_pkg::t_flags        i_flags,
    input  wire logic [ramp_pkg::X_W-1:0] i_x,
    input  wire ramp_pkg::t_cfg          i_cfg,
    output logic                         o_vld,
    output logic [15:0]                  o_alpha
);
    import ramp_pkg::*;

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    t_flags               r_f1, r_f2, r_f3, r_f4, r_f5, r_f6;
    logic signed [X_W:0]  r_x1, r_x2, r_x3, r_x4;
    logic signed [P_W-1:0] r_p1, r_p2, r_p3;
    logic signed [CW-1:0] r_t1, r_t2, r_y;
    logic [CW-1:0]        mag;
    logic [15:0]          sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, o_vld} <= '0;
        end else if (i_en) begin
            {r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, o_vld} <=
                {i_vld, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6};
        end
    end

    // Horner: t1 = a2 + a3*x, t2 = s0 + t1*x, y = 1 + t2*x
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f1 <= i_flags;
            r_f2 <= r_f1;
            r_f3 <= r_f2;
            r_f4 <= r_f3;
            r_f5 <= r_f4;
            r_f6 <= r_f5;
            r_x1 <= $signed({1'b0, i_x});
            r_x2 <= r_x1;
            r_x3 <= r_x2;
            r_x4 <= r_x3;
            r_p1 <= P_W'(i_cfg.a3) * P_W'($signed({1'b0, i_x}));
            r_t1 <= i_cfg.a2 + CW'(r_p1 >>> FRAC_BITS);
            r_p2 <= P_W'(r_t1) * P_W'(r_x2);
            r_t2 <= i_cfg.s0 + CW'(r_p2 >>> FRAC_BITS);
            r_p3 <= P_W'(r_t2) * P_W'(r_x4);
            r_y  <= UNIT + CW'(r_p3 >>> FRAC_BITS);
        end
    end

    assign mag = r_y[CW-1] ? CW'(-r_y) : CW'(r_y);
    assign sat = (|mag[CW-1:32]) ? ALPHA_MAX : mag[31:16];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_f6.opaque) begin
                o_alpha <= ALPHA_MAX;
            end else if (r_f6.zero) begin
                o_alpha <= '0;
            end else begin
                o_alpha <= sat;
            end
        end
    end
endmodule
`default_nettype wire

### design/radial_alpha_mask_pixel.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload                 Transfer
// i_pix     in   col[9:0], row[9:0]      valid && ready
// o_alpha   out  alpha[15:0]             valid && ready
// APB       in   regs at 0x0/0x4/0x8/0xC psel && penable && pwrite
//
// One pixel per cycle sustained while results are taken; an accepted transaction
// passes through 58 stages of distance (35-step long division of the squared
// offset by size^2, then an 18-digit root), 18 stages for the band divide,
// 7 for the cubic bell including the output register, before it reaches o_alpha.
// Reset clears all valid bits and the registers, but sets the size register to 5; no clearing pass.
// A held result freezes the whole pipeline; i_pix.ready drops with it.
module radial_alpha_mask_pixel (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    ramp_pix_if.sink                         i_pix,
    ramp_alpha_if.source                     o_alpha,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ramp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import ramp_pkg::*;
    `include "radial_alpha_mask_pixel_assert.svh"

    t_cfg             cfg;
    logic             en;
    logic             dist_vld;
    logic             dist_kill;
    logic [D_W-1:0]   dist_d;
    logic             band_vld;
    t_flags           band_fl;
    logic [X_W-1:0]   band_x;

    // Advance every stage together unless the output holds an untaken result.
    assign en          = !o_alpha.valid || o_alpha.ready;
    assign i_pix.ready = en;

    ramp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Normalized distance, Q2.16; kill marks zero size or d above 2.0.
    ramp_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_pix.valid && i_pix.ready),
        .i_col   (i_pix.col),
        .i_row   (i_pix.row),
        .i_cfg   (cfg),
        .o_vld   (dist_vld),
        .o_kill  (dist_kill),
        .o_d     (dist_d)
    );

    // Classify and map d onto the transition band.
    ramp_band u_band (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (dist_vld),
        .i_kill  (dist_kill),
        .i_d     (dist_d),
        .i_cfg   (cfg),
        .o_vld   (band_vld),
        .o_flags (band_fl),
        .o_x     (band_x)
    );

    // Evaluate the bell and saturate; last stage is the output register.
    ramp_bell u_bell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (band_vld),
        .i_flags (band_fl),
        .i_x     (band_x),
        .i_cfg   (cfg),
        .o_vld   (o_alpha.valid),
        .o_alpha (o_alpha.alpha)
    );

    `RAMP_ASSERT_IMP(a_zero_size, i_clk, i_rst_n,
        o_alpha.valid && cfg.zero_size, o_alpha.alpha == '0,
        "zero mask size must give alpha 0")
    `RAMP_ASSERT_IMP(a_big_flat, i_clk, i_rst_n,
        o_alpha.valid && (cfg.flat > ONE),
        (o_alpha.alpha == '0) || (o_alpha.alpha == ALPHA_MAX),
        "flat radius above one leaves no band")
endmodule
`default_nettype wire
